@@ src/ucl_pkg.sv @@
// Shared types and constants for the UPGMA similarity clustering core.
// Holds the controller/datapath command and status structs.
// No dependencies.
package ucl_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int CFG_W = 7;
	localparam int SIM_W = 32;
	localparam logic [CFG_W-1:0] ITEM_COUNT_RST = 7'd64;
	// Running best starts just above the most negative word.
	localparam logic signed [SIM_W-1:0] SIM_FLOOR = -32'sh7FFFFFFF;

	typedef struct packed {
		logic load;
		logic sel_best;
		logic fb_init;
		logic fb_c_inc;
		logic fb_r_init;
		logic fb_r_inc;
		logic rd_rc;
		logic cap_s_ci;
		logic cap_cj;
		logic k_inc;
		logic rd_a;
		logic cap_a;
		logic cap_b;
		logic mul;
		logic add;
		logic div_start;
		logic wr_m;
		logic merge_done;
		logic i_inc;
		logic rd_size_i;
		logic cap_size_i;
		logic j_inc;
		logic rd_ij;
		logic cmp_ij;
		logic clear;
	} ucl_cmd_t;

	typedef struct packed {
		logic sel_ok;
		logic c_live;
		logic r_stop;
		logic k_end;
		logic k_skip;
		logic div_done;
		logic last_merge;
		logic i_end;
		logic i_dead;
		logic j_end;
		logic j_dead;
	} ucl_status_t;

endpackage

@@ src/ucl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ucl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/ucl_ctrl.sv @@
// Sequencing state machine for the clustering core.
// Depends on ucl_pkg for the command and status structs.
module ucl_ctrl import ucl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_pair,
	input  ucl_status_t st,
	output ucl_cmd_t    cmd,
	output logic        busy
);

	typedef enum logic [4:0] {
		IDLE, SEL, FBC, FBR, RD1, RD2, RD3, KS, KA, KB, MUL, ADD, DS, DIV,
		SZ, SI, SI2, SJ, SV, CLR
	} state_t;

	state_t state_q, state_d;
	logic busy_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				cmd.load = start;
				if (start && last_pair) state_d = SEL;
			end
			SEL: begin
				if (st.sel_ok) begin
					cmd.sel_best = 1'b1;
					state_d = RD1;
				end else begin
					cmd.fb_init = 1'b1;
					state_d = FBC;
				end
			end
			FBC: begin
				if (st.c_live) begin
					cmd.fb_r_init = 1'b1;
					state_d = FBR;
				end else begin
					cmd.fb_c_inc = 1'b1;
				end
			end
			FBR: begin
				if (st.r_stop) state_d = RD1;
				else cmd.fb_r_inc = 1'b1;
			end
			RD1: begin
				cmd.rd_rc = 1'b1;
				state_d = RD2;
			end
			RD2: begin
				cmd.cap_s_ci = 1'b1;
				state_d = RD3;
			end
			RD3: begin
				cmd.cap_cj = 1'b1;
				state_d = KS;
			end
			KS: begin
				if (st.k_end) begin
					state_d = SZ;
				end else if (st.k_skip) begin
					cmd.k_inc = 1'b1;
				end else begin
					cmd.rd_a = 1'b1;
					state_d = KA;
				end
			end
			KA: begin
				cmd.cap_a = 1'b1;
				state_d = KB;
			end
			KB: begin
				cmd.cap_b = 1'b1;
				state_d = MUL;
			end
			MUL: begin
				cmd.mul = 1'b1;
				state_d = ADD;
			end
			ADD: begin
				cmd.add = 1'b1;
				state_d = DS;
			end
			DS: begin
				cmd.div_start = 1'b1;
				state_d = DIV;
			end
			DIV: begin
				if (st.div_done) begin
					cmd.wr_m = 1'b1;
					state_d = KS;
				end
			end
			SZ: begin
				cmd.merge_done = 1'b1;
				state_d = st.last_merge ? CLR : SI;
			end
			SI: begin
				if (st.i_end) begin
					state_d = SEL;
				end else if (st.i_dead) begin
					cmd.i_inc = 1'b1;
				end else begin
					cmd.rd_size_i = 1'b1;
					state_d = SI2;
				end
			end
			SI2: begin
				cmd.cap_size_i = 1'b1;
				state_d = SJ;
			end
			SJ: begin
				if (st.j_end) begin
					cmd.i_inc = 1'b1;
					state_d = SI;
				end else if (st.j_dead) begin
					cmd.j_inc = 1'b1;
				end else begin
					cmd.rd_ij = 1'b1;
					state_d = SV;
				end
			end
			SV: begin
				cmd.cmp_ij = 1'b1;
				state_d = SJ;
			end
			CLR: begin
				cmd.clear = 1'b1;
				state_d = IDLE;
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= (state_d != IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ src/ucl_dp.sv @@
// Datapath: similarity store, cluster sizes, dead flags, mean update with a
// bit-serial divider, and the best-pair scan. Depends on ucl_pkg and ucl_ram.
module ucl_dp import ucl_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ucl_cmd_t                      cmd,
	output ucl_status_t                   st,
	input  logic                          cfg_wr_en,
	input  logic [CFG_W-1:0]              cfg_wr_data,
	input  logic signed [SIM_W-1:0]       similarity,
	input  logic                          last_pair,
	output logic                          result_strobe,
	output logic [$clog2(MAX_ITEMS)-1:0]  kept_cluster,
	output logic [$clog2(MAX_ITEMS)-1:0]  absorbed_cluster,
	output logic signed [SIM_W-1:0]       merge_similarity,
	output logic                          last_merge
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int SW = $clog2(MAX_ITEMS + 1);
	localparam int AW = 2 * IW;
	localparam int PW = SIM_W + SW + 1;
	localparam int NW = PW + 1;
	localparam int CW = $clog2(NW + 1);

	logic [CFG_W-1:0] item_count_q;
	logic [SW-1:0] n;

	logic [SW-1:0] load_row_q;
	logic [IW-1:0] load_col_q;
	logic [IW-1:0] best_row_q, best_col_q;
	logic signed [SIM_W-1:0] best_val_q;
	logic best_vld_q;
	logic [SW-1:0] best_sz_q;
	logic [IW-1:0] r_q, c_q;
	logic [SW-1:0] k_q, i_q, j_q, alive_q;
	logic [MAX_ITEMS-1:0] dead_q, size_vld_q;
	logic size_rvld_q;

	logic signed [SIM_W-1:0] s_q, a_q, b_q;
	logic [SW-1:0] ci_q, cj_q, szi_q;
	logic signed [PW-1:0] p1_q, p2_q;
	logic signed [NW-1:0] sum_q;
	logic [NW-1:0] quo_q;
	logic [SW-1:0] rem_q, den_q;
	logic neg_q;
	logic [CW-1:0] div_cnt_q;
	logic div_busy_q;

	logic sim_we;
	logic [AW-1:0] sim_waddr, sim_raddr;
	logic signed [SIM_W-1:0] sim_wdata, sim_rdata;
	logic size_we;
	logic [IW-1:0] size_raddr;
	logic [SW-1:0] size_rdata, size_val, sz_sum;
	logic [AW-1:0] addr_rk, addr_ck;
	logic signed [SIM_W-1:0] m_val;
	logic [SW:0] div_t;
	logic div_ge;

	always_comb begin
		if (item_count_q < CFG_W'(2)) n = SW'(2);
		else if (32'(item_count_q) > 32'(MAX_ITEMS)) n = SW'(MAX_ITEMS);
		else n = SW'(item_count_q);
	end

	assign sz_sum = ci_q + cj_q;
	assign size_val = size_rvld_q ? size_rdata : SW'(1);
	assign addr_rk = (k_q > SW'(r_q)) ? {k_q[IW-1:0], r_q} : {r_q, k_q[IW-1:0]};
	assign addr_ck = (k_q > SW'(c_q)) ? {k_q[IW-1:0], c_q} : {c_q, k_q[IW-1:0]};
	assign m_val = neg_q ? SIM_W'(-quo_q[SIM_W-1:0]) : quo_q[SIM_W-1:0];
	assign div_t = {rem_q, quo_q[NW-1]};
	assign div_ge = (div_t >= {1'b0, den_q});

	// status toward the controller
	always_comb begin
		st.sel_ok = best_vld_q && (SW'(best_row_q) < n) && (best_col_q < best_row_q)
			&& !dead_q[best_row_q] && !dead_q[best_col_q];
		st.c_live = !dead_q[c_q];
		st.r_stop = !dead_q[r_q] || (SW'(r_q) >= n);
		st.k_end = (k_q == n);
		st.k_skip = (k_q == SW'(r_q)) || dead_q[k_q[IW-1:0]];
		st.div_done = !div_busy_q;
		st.last_merge = (alive_q == SW'(1));
		st.i_end = (i_q == n);
		st.i_dead = dead_q[i_q[IW-1:0]];
		st.j_end = (j_q == i_q);
		st.j_dead = dead_q[j_q[IW-1:0]];
	end

	// memory ports
	always_comb begin
		sim_we = 1'b0;
		sim_waddr = {load_row_q[IW-1:0], load_col_q};
		sim_wdata = similarity;
		sim_raddr = {r_q, c_q};
		if (cmd.load) begin
			sim_we = (load_row_q < n);
		end else if (cmd.wr_m) begin
			sim_we = 1'b1;
			sim_waddr = addr_rk;
			sim_wdata = m_val;
		end
		if (cmd.rd_a) sim_raddr = addr_rk;
		else if (cmd.cap_a) sim_raddr = addr_ck;
		else if (cmd.rd_ij) sim_raddr = {i_q[IW-1:0], j_q[IW-1:0]};
		size_we = cmd.merge_done;
		if (cmd.cap_s_ci) size_raddr = c_q;
		else if (cmd.rd_size_i) size_raddr = i_q[IW-1:0];
		else size_raddr = r_q;
	end

	ucl_ram #(.WIDTH(SIM_W), .DEPTH(1 << AW)) u_sim_ram (
		.clk(clk), .we(sim_we), .waddr(sim_waddr), .wdata(sim_wdata),
		.raddr(sim_raddr), .rdata(sim_rdata)
	);

	ucl_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_size_ram (
		.clk(clk), .we(size_we), .waddr(r_q), .wdata(sz_sum),
		.raddr(size_raddr), .rdata(size_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= ITEM_COUNT_RST;
			load_row_q <= SW'(1);
			load_col_q <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
			best_val_q <= SIM_FLOOR;
			best_vld_q <= 1'b0;
			best_sz_q <= '0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			alive_q <= '0;
			dead_q <= '0;
			size_vld_q <= '0;
			size_rvld_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
			result_strobe <= 1'b0;
		end else begin
			if (cfg_wr_en) item_count_q <= cfg_wr_data;
			size_rvld_q <= size_vld_q[size_raddr];
			result_strobe <= cmd.merge_done;
			if (cmd.load) begin
				if (load_row_q < n) begin
					if (similarity > best_val_q) begin
						best_val_q <= similarity;
						best_row_q <= load_row_q[IW-1:0];
						best_col_q <= load_col_q;
						best_vld_q <= 1'b1;
					end
					if (SW'(load_col_q) + SW'(1) >= load_row_q) begin
						load_row_q <= load_row_q + SW'(1);
						load_col_q <= '0;
					end else begin
						load_col_q <= load_col_q + IW'(1);
					end
				end
				if (last_pair) alive_q <= n;
			end
			if (cmd.sel_best) begin
				r_q <= best_row_q;
				c_q <= best_col_q;
			end
			if (cmd.fb_init) c_q <= '0;
			if (cmd.fb_c_inc) c_q <= c_q + IW'(1);
			if (cmd.fb_r_init) r_q <= c_q + IW'(1);
			if (cmd.fb_r_inc) r_q <= r_q + IW'(1);
			if (cmd.cap_cj) begin
				dead_q[c_q] <= 1'b1;
				alive_q <= alive_q - SW'(1);
				k_q <= '0;
			end
			if (cmd.k_inc || cmd.wr_m) k_q <= k_q + SW'(1);
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= CW'(NW);
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - CW'(1);
				if (div_cnt_q == CW'(1)) div_busy_q <= 1'b0;
			end
			if (cmd.merge_done) begin
				size_vld_q[r_q] <= 1'b1;
				best_row_q <= r_q;
				best_col_q <= c_q;
				best_vld_q <= 1'b0;
				best_val_q <= SIM_FLOOR;
				best_sz_q <= sz_sum;
				i_q <= SW'(1);
			end
			if (cmd.i_inc) i_q <= i_q + SW'(1);
			if (cmd.rd_size_i) j_q <= '0;
			if (cmd.j_inc) j_q <= j_q + SW'(1);
			if (cmd.cmp_ij) begin
				j_q <= j_q + SW'(1);
				if (sim_rdata > best_val_q
						|| (sim_rdata == best_val_q && szi_q > best_sz_q)) begin
					best_val_q <= sim_rdata;
					best_row_q <= i_q[IW-1:0];
					best_col_q <= j_q[IW-1:0];
					best_vld_q <= 1'b1;
					best_sz_q <= szi_q;
				end
			end
			if (cmd.clear) begin
				dead_q <= '0;
				size_vld_q <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
				best_val_q <= SIM_FLOOR;
				best_vld_q <= 1'b0;
				load_row_q <= SW'(1);
				load_col_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap_s_ci) begin
			s_q <= sim_rdata;
			ci_q <= size_val;
		end
		if (cmd.cap_cj) cj_q <= size_val;
		if (cmd.cap_a) a_q <= sim_rdata;
		if (cmd.cap_b) b_q <= sim_rdata;
		if (cmd.cap_size_i) szi_q <= size_val;
		if (cmd.mul) begin
			p1_q <= PW'(a_q * $signed({1'b0, ci_q}));
			p2_q <= PW'(b_q * $signed({1'b0, cj_q}));
		end
		if (cmd.add) sum_q <= NW'(p1_q) + NW'(p2_q);
		if (cmd.div_start) begin
			neg_q <= sum_q[NW-1];
			quo_q <= sum_q[NW-1] ? NW'(-sum_q) : sum_q;
			rem_q <= '0;
			den_q <= sz_sum;
		end else if (div_busy_q) begin
			rem_q <= div_ge ? SW'(div_t - {1'b0, den_q}) : SW'(div_t);
			quo_q <= {quo_q[NW-2:0], div_ge};
		end
		if (cmd.merge_done) begin
			kept_cluster <= r_q;
			absorbed_cluster <= c_q;
			merge_similarity <= s_q;
			last_merge <= (alive_q == SW'(1));
		end
	end

endmodule

@@ src/upgma_similarity_clustering_core.sv @@
// UPGMA similarity clustering core. Load: one similarity per cycle, busy stays
// low until the request carrying last_pair. Merge phase: each merge updates
// the mean for every live partner with a bit-serial divider (NW = 41 bits at
// 64 items), then rescans the live rows and pairs for the next best pair.
// One merge result per strobe, no stall. arst_n clears control state; the
// similarity store is not cleared.
module upgma_similarity_clustering_core import ucl_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_W-1:0]              cfg_wr_data,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SIM_W-1:0]       similarity,
	input  logic                          last_pair,
	output logic                          result_strobe,
	output logic [$clog2(MAX_ITEMS)-1:0]  kept_cluster,
	output logic [$clog2(MAX_ITEMS)-1:0]  absorbed_cluster,
	output logic signed [SIM_W-1:0]       merge_similarity,
	output logic                          last_merge
);

	ucl_cmd_t    cmd;
	ucl_status_t st;

	// Sequence load, pair selection, mean update and rescan.
	ucl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_pair(last_pair),
		.st(st), .cmd(cmd), .busy(busy)
	);

	// Hold the store, sizes, dead flags, divider and result registers.
	ucl_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.similarity(similarity), .last_pair(last_pair),
		.result_strobe(result_strobe), .kept_cluster(kept_cluster),
		.absorbed_cluster(absorbed_cluster), .merge_similarity(merge_similarity),
		.last_merge(last_merge)
	);

	// A result only appears inside a merge run.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy) else $error("result outside merge run");

	// The final request starts the merge run.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_pair) |=> busy) else $error("merge run not started");

	// The final merge ends the run.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_merge) |=> !busy) else $error("run did not end");

	// Kept and absorbed clusters always differ.
	a_pair_diff: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (kept_cluster != absorbed_cluster))
		else $error("merge of a cluster with itself");

endmodule
